>>> design/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/grap_pkg.sv
// ----------------------------------------------------------------------------
// grap_pkg
// Shared types and constants of the grid rectangle atlas packer.
// ----------------------------------------------------------------------------
package grap_pkg;

    localparam int DEF_MAX_PAGES   = 8;
    localparam int DEF_MAX_COLUMNS = 16;
    localparam int DEF_MAX_ROWS    = 16;
    localparam int DEF_MAX_SIDE    = 4096;

    localparam logic [12:0] SIDE_RESET = 13'd1024;

    typedef enum logic [1:0] {
        ST_PLACED   = 2'd0,
        ST_CLEARED  = 2'd1,
        ST_FULL     = 2'd2,
        ST_OVERSIZE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PG_START,
        S_COL_RD,
        S_COL_CHK,
        S_ROW_RD,
        S_ROW_CHK,
        S_DECIDE,
        S_APPLY,
        S_RES_RD,
        S_RES_CAP,
        S_NEW,
        S_CLR,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        GR_NONE,
        GR_COL,
        GR_ROW,
        GR_BOTH
    } grow_t;

endpackage

>>> design/grid_rectangle_atlas_packer.sv
// ----------------------------------------------------------------------------
// grid_rectangle_atlas_packer
// Places rectangles on grid-managed square atlas pages.
// ----------------------------------------------------------------------------
// Input stream: s_tdata = {rect_height, rect_width}, s_tuser = mode
// (0 place, 1 clear all pages). One result per input on the m_ stream:
// m_tdata = {corner_y, corner_x, page_index}, m_tuser = status.
// atlas_side is written through cfg_wr_en/cfg_wr_data; the user must do so
// only while idle, as the block itself does not enforce it.
//
// The block takes one item at a time; s_tready is high only when the
// sequencer is idle. A placement walks the pages in order; for each page it
// reads every column, then the rows with their cell words until one has a
// free cell that fits, through one shared extent compare unit; if none fits,
// it decides on growth. Opening a new page clears its cell words. Clear and
// oversize items go from idle straight to output. The result sits in an
// output register, so the next item is accepted while it waits; a stalled
// receiver holds the block only when a second result is ready.
// Reset empties all pages and sets atlas_side to 1024.
// ----------------------------------------------------------------------------
module grid_rectangle_atlas_packer #(
    parameter int MAX_PAGES   = grap_pkg::DEF_MAX_PAGES,
    parameter int MAX_COLUMNS = grap_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = grap_pkg::DEF_MAX_ROWS,
    parameter int MAX_SIDE    = grap_pkg::DEF_MAX_SIDE
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [12:0] rect_width, [25:13] rect_height
    input  logic        s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [2:0] page_index, [14:3] corner_x, [26:15] corner_y
    output logic [1:0]  m_tuser    // [1:0] status
);
    import grap_pkg::*;

    localparam int PW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PCW = $clog2(MAX_PAGES + 1);
    localparam int CLW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CCW = $clog2(MAX_COLUMNS + 1);
    localparam int RLW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CW  = $clog2(MAX_SIDE + 1);
    localparam int XW  = (CW > 13) ? CW : 13;

    state_t state_reg, state_next;

    logic [12:0]   side_cfg_reg;
    logic [XW-1:0] side_x;
    logic [CW-1:0] side;

    logic [PCW-1:0] page_count_reg;
    logic [PCW-1:0] page_reg;
    logic [PW-1:0]  pg;
    logic [CW-1:0]  w_reg, h_reg;
    logic           wlt_reg;

    logic [CCW-1:0] col_cnt_reg [MAX_PAGES];
    logic [RCW-1:0] row_cnt_reg [MAX_PAGES];
    logic [CW-1:0]  used_x_reg  [MAX_PAGES];
    logic [CW-1:0]  used_y_reg  [MAX_PAGES];
    logic [CCW-1:0] cur_col_cnt;
    logic [RCW-1:0] cur_row_cnt;
    logic [CW-1:0]  cur_used_x, cur_used_y;

    logic [CCW-1:0] col_idx_reg;
    logic [RCW-1:0] row_idx_reg;

    // column word {right, left}, row word {bottom, top}
    logic [2*CW-1:0]        col_mem  [2**(PW+CLW)];
    logic [2*CW-1:0]        row_mem  [2**(PW+RLW)];
    logic [MAX_COLUMNS-1:0] cell_mem [2**(PW+RLW)];
    logic [2*CW-1:0]        col_q, row_q;
    logic [MAX_COLUMNS-1:0] cell_q;
    logic [PW+CLW-1:0]      col_raddr, col_waddr;
    logic [PW+RLW-1:0]      row_raddr, row_waddr, cell_waddr;
    logic [2*CW-1:0]        col_wdata, row_wdata;
    logic [MAX_COLUMNS-1:0] cell_wdata;
    logic                   col_we, row_we, cell_we;

    logic [MAX_COLUMNS-1:0] wide_mask_reg;
    logic [CLW-1:0]         wide_first_reg;
    logic                   rt_reg;
    logic [RLW-1:0]         tall_row_reg;
    logic [MAX_COLUMNS-1:0] tall_word_reg;

    logic [RLW-1:0]         sel_row_reg;
    logic [CLW-1:0]         sel_col_reg;
    logic [MAX_COLUMNS-1:0] sel_word_reg;
    grow_t                  grow_reg;

    logic [CW-1:0] res_x_reg, res_y_reg;
    status_t       res_status_reg;
    logic          m_tvalid_reg;
    logic [31:0]   m_tdata_reg;
    logic [1:0]    m_tuser_reg;

    logic          in_acc, in_bad;
    logic [12:0]   in_w, in_h;
    logic [CW-1:0] cmp_hi, cmp_lo, cmp_thr;
    logic          cmp_ge;
    logic [MAX_COLUMNS-1:0] fit_mask;
    logic          cf, rf, cw_any;
    grow_t         grow_sel;
    logic          out_load;

    function automatic logic [CLW-1:0] first_set(input logic [MAX_COLUMNS-1:0] v);
        logic [CLW-1:0] idx;
        logic           hit;
        idx = '0;
        hit = 1'b0;
        for (int i = 0; i < MAX_COLUMNS; i++) begin
            if (v[i] && !hit) begin
                idx = CLW'(i);
                hit = 1'b1;
            end
        end
        return idx;
    endfunction

    assign side_x = (XW'(side_cfg_reg) > XW'(MAX_SIDE)) ? XW'(MAX_SIDE) : XW'(side_cfg_reg);
    assign side   = CW'(side_x);

    assign in_w   = s_tdata[12:0];
    assign in_h   = s_tdata[25:13];
    assign in_acc = s_tvalid && s_tready;
    assign in_bad = (in_w == 13'd0) || (in_h == 13'd0) ||
                    (XW'(in_w) > side_x) || (XW'(in_h) > side_x);

    assign pg          = page_reg[PW-1:0];
    assign cur_col_cnt = col_cnt_reg[pg];
    assign cur_row_cnt = row_cnt_reg[pg];
    assign cur_used_x  = used_x_reg[pg];
    assign cur_used_y  = used_y_reg[pg];

    // shared extent compare: column width against w, row height against h
    always_comb begin
        if (state_reg == S_COL_CHK) begin
            cmp_hi  = col_q[2*CW-1:CW];
            cmp_lo  = col_q[CW-1:0];
            cmp_thr = w_reg;
        end else begin
            cmp_hi  = row_q[2*CW-1:CW];
            cmp_lo  = row_q[CW-1:0];
            cmp_thr = h_reg;
        end
    end
    assign cmp_ge   = (cmp_hi - cmp_lo) >= cmp_thr;
    assign fit_mask = wide_mask_reg & ~cell_q;

    assign cw_any = |wide_mask_reg;
    assign cf = (cur_col_cnt < CCW'(MAX_COLUMNS)) &&
                (({1'b0, w_reg} + {1'b0, cur_used_x}) <= {1'b0, side});
    assign rf = (cur_row_cnt < RCW'(MAX_ROWS)) &&
                (({1'b0, h_reg} + {1'b0, cur_used_y}) <= {1'b0, side});

    always_comb begin
        logic cr_col, cr_row, rc_row, rc_col;
        cr_col = rt_reg && cf;
        cr_row = rt_reg && !cf && cw_any && rf;
        rc_row = cw_any && rf;
        rc_col = cw_any && !rf && rt_reg && cf;
        grow_sel = GR_NONE;
        if (wlt_reg) begin
            if (cr_col)      grow_sel = GR_COL;
            else if (cr_row) grow_sel = GR_ROW;
            else if (rc_row) grow_sel = GR_ROW;
            else if (rc_col) grow_sel = GR_COL;
            else if (cf && rf) grow_sel = GR_BOTH;
        end else begin
            if (rc_row)      grow_sel = GR_ROW;
            else if (rc_col) grow_sel = GR_COL;
            else if (cr_col) grow_sel = GR_COL;
            else if (cr_row) grow_sel = GR_ROW;
            else if (cf && rf) grow_sel = GR_BOTH;
        end
    end

    // memory ports
    always_comb begin
        col_raddr = {pg, col_idx_reg[CLW-1:0]};
        row_raddr = {pg, row_idx_reg[RLW-1:0]};
        if (state_reg == S_RES_RD) begin
            col_raddr = {pg, sel_col_reg};
            row_raddr = {pg, sel_row_reg};
        end
        col_we    = 1'b0;
        row_we    = 1'b0;
        cell_we   = 1'b0;
        col_waddr = {pg, cur_col_cnt[CLW-1:0]};
        row_waddr = {pg, cur_row_cnt[RLW-1:0]};
        col_wdata = {cur_used_x + w_reg, cur_used_x};
        row_wdata = {cur_used_y + h_reg, cur_used_y};
        cell_waddr = {pg, sel_row_reg};
        cell_wdata = sel_word_reg;
        case (state_reg)
            S_APPLY: begin
                cell_we = 1'b1;
                col_we  = (grow_reg == GR_COL) || (grow_reg == GR_BOTH);
                row_we  = (grow_reg == GR_ROW) || (grow_reg == GR_BOTH);
            end
            S_NEW: begin
                col_we    = 1'b1;
                row_we    = 1'b1;
                col_waddr = {pg, {CLW{1'b0}}};
                row_waddr = {pg, {RLW{1'b0}}};
                col_wdata = {w_reg, {CW{1'b0}}};
                row_wdata = {h_reg, {CW{1'b0}}};
            end
            S_CLR: begin
                cell_we    = 1'b1;
                cell_waddr = {pg, row_idx_reg[RLW-1:0]};
                cell_wdata = (row_idx_reg == '0) ? MAX_COLUMNS'(1) : '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (col_we) col_mem[col_waddr] <= col_wdata;
        col_q <= col_mem[col_raddr];
    end

    always_ff @(posedge aclk) begin
        if (row_we) row_mem[row_waddr] <= row_wdata;
        row_q <= row_mem[row_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
        cell_q <= cell_mem[row_raddr];
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign out_load = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_tuser || in_bad) state_next = S_OUT;
                    else                   state_next = S_PG_START;
                end
            end
            S_PG_START: begin
                if (page_reg == page_count_reg) begin
                    if (page_count_reg == PCW'(MAX_PAGES)) state_next = S_OUT;
                    else                                   state_next = S_NEW;
                end else begin
                    state_next = S_COL_RD;
                end
            end
            S_COL_RD:  state_next = (col_idx_reg == cur_col_cnt) ? S_ROW_RD : S_COL_CHK;
            S_COL_CHK: state_next = S_COL_RD;
            S_ROW_RD:  state_next = (row_idx_reg == cur_row_cnt) ? S_DECIDE : S_ROW_CHK;
            S_ROW_CHK: state_next = (cmp_ge && (fit_mask != '0)) ? S_APPLY : S_ROW_RD;
            S_DECIDE:  state_next = (grow_sel == GR_NONE) ? S_PG_START : S_APPLY;
            S_APPLY:   state_next = S_RES_RD;
            S_RES_RD:  state_next = S_RES_CAP;
            S_RES_CAP: state_next = S_OUT;
            S_NEW:     state_next = S_CLR;
            S_CLR:     state_next = (row_idx_reg == RCW'(MAX_ROWS - 1)) ? S_OUT : S_CLR;
            S_OUT:     state_next = out_load ? S_IDLE : S_OUT;
            default:   state_next = S_IDLE;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_cfg_reg   <= SIDE_RESET;
            page_count_reg <= '0;
        end else begin
            if (cfg_wr_en) side_cfg_reg <= cfg_wr_data;
            if (state_reg == S_IDLE && in_acc && s_tuser) page_count_reg <= '0;
            if (state_reg == S_NEW) page_count_reg <= page_count_reg + PCW'(1);
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                w_reg     <= CW'(in_w);
                h_reg     <= CW'(in_h);
                wlt_reg   <= in_w < in_h;
                page_reg  <= '0;
                res_x_reg <= '0;
                res_y_reg <= '0;
                if (s_tuser)     res_status_reg <= ST_CLEARED;
                else if (in_bad) res_status_reg <= ST_OVERSIZE;
                else             res_status_reg <= ST_PLACED;
            end
            S_PG_START: begin
                col_idx_reg   <= '0;
                row_idx_reg   <= '0;
                wide_mask_reg <= '0;
                rt_reg        <= 1'b0;
                if (page_reg == page_count_reg && page_count_reg == PCW'(MAX_PAGES)) begin
                    res_status_reg <= ST_FULL;
                end
            end
            S_COL_CHK: begin
                if (cmp_ge) begin
                    wide_mask_reg[col_idx_reg[CLW-1:0]] <= 1'b1;
                    if (wide_mask_reg == '0) wide_first_reg <= col_idx_reg[CLW-1:0];
                end
                col_idx_reg <= col_idx_reg + CCW'(1);
            end
            S_ROW_CHK: begin
                if (cmp_ge && !rt_reg) begin
                    rt_reg        <= 1'b1;
                    tall_row_reg  <= row_idx_reg[RLW-1:0];
                    tall_word_reg <= cell_q;
                end
                sel_row_reg  <= row_idx_reg[RLW-1:0];
                sel_col_reg  <= first_set(fit_mask);
                sel_word_reg <= cell_q | (MAX_COLUMNS'(1) << first_set(fit_mask));
                grow_reg     <= GR_NONE;
                row_idx_reg  <= row_idx_reg + RCW'(1);
            end
            S_DECIDE: begin
                grow_reg <= grow_sel;
                case (grow_sel)
                    GR_COL: begin
                        sel_row_reg  <= tall_row_reg;
                        sel_col_reg  <= cur_col_cnt[CLW-1:0];
                        sel_word_reg <= tall_word_reg |
                                        (MAX_COLUMNS'(1) << cur_col_cnt[CLW-1:0]);
                    end
                    GR_ROW: begin
                        sel_row_reg  <= cur_row_cnt[RLW-1:0];
                        sel_col_reg  <= wide_first_reg;
                        sel_word_reg <= MAX_COLUMNS'(1) << wide_first_reg;
                    end
                    GR_BOTH: begin
                        sel_row_reg  <= cur_row_cnt[RLW-1:0];
                        sel_col_reg  <= cur_col_cnt[CLW-1:0];
                        sel_word_reg <= MAX_COLUMNS'(1) << cur_col_cnt[CLW-1:0];
                    end
                    default: page_reg <= page_reg + PCW'(1);
                endcase
            end
            S_APPLY: begin
                if (grow_reg == GR_COL || grow_reg == GR_BOTH) begin
                    col_cnt_reg[pg] <= cur_col_cnt + CCW'(1);
                    used_x_reg[pg]  <= cur_used_x + w_reg;
                end
                if (grow_reg == GR_ROW || grow_reg == GR_BOTH) begin
                    row_cnt_reg[pg] <= cur_row_cnt + RCW'(1);
                    used_y_reg[pg]  <= cur_used_y + h_reg;
                end
            end
            S_RES_CAP: begin
                res_x_reg <= col_q[CW-1:0];
                res_y_reg <= row_q[CW-1:0];
            end
            S_NEW: begin
                col_cnt_reg[pg] <= CCW'(1);
                row_cnt_reg[pg] <= RCW'(1);
                used_x_reg[pg]  <= w_reg;
                used_y_reg[pg]  <= h_reg;
                row_idx_reg     <= '0;
            end
            S_CLR: begin
                row_idx_reg <= row_idx_reg + RCW'(1);
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == S_OUT && out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && out_load) begin
            m_tuser_reg <= res_status_reg;
            if (res_status_reg == ST_PLACED) begin
                m_tdata_reg <= {5'd0, 12'(res_y_reg), 12'(res_x_reg), 3'(page_reg)};
            end else begin
                m_tdata_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> design/grap_checker.sv
// ----------------------------------------------------------------------------
// grap_checker
// Port-level checks on the atlas packer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grap_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import grap_pkg::*;

    // stalled result stays valid
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

    // only placements carry page and corner
    `ASSERT_ALWAYS(a_zero_payload, aclk, aresetn,
                   !m_tvalid || (m_tuser == ST_PLACED) || (m_tdata == 32'd0))

    // one item at a time: busy right after a transfer in
    `ASSERT_NEXT(a_busy_after_in, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

bind grid_rectangle_atlas_packer grap_checker u_grap_checker (.*);
